[rtl/core/pwsfr_pkg.sv]
// shared types, constants and register indexes for the pulse width sensor frame reader
// no dependencies; imported by every module of the block
package pwsfr_pkg;

	// frame geometry
	localparam int FRAME_BITS = 40;
	localparam int BIT_CNT_W  = $clog2(FRAME_BITS + 1);

	// register widths
	localparam int TIMEOUT_W   = 8;
	localparam int THRESH_W    = 8;
	localparam int PRE_HIGH_W  = 18;
	localparam int START_LOW_W = 16;
	localparam int RELEASE_W   = 8;
	localparam int CFG_DATA_W  = 18;
	localparam int CFG_IDX_W   = 3;

	// counter widths
	localparam int PHASE_TICKS_W = 18;
	localparam int EDGE_CNT_W    = 7;
	localparam int PULSE_W       = 8;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_SENSOR_KIND  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIT_THRESH   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PRE_HIGH     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_START_LOW    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_RELEASE_HIGH = 3'd5;

	// register reset values
	localparam logic                   RST_SENSOR_KIND  = 1'b0;
	localparam logic [TIMEOUT_W-1:0]   RST_TIMEOUT      = 8'd250;
	localparam logic [THRESH_W-1:0]    RST_BIT_THRESH   = 8'd40;
	localparam logic [PRE_HIGH_W-1:0]  RST_PRE_HIGH     = 18'd250000;
	localparam logic [START_LOW_W-1:0] RST_START_LOW    = 16'd20000;
	localparam logic [RELEASE_W-1:0]   RST_RELEASE_HIGH = 8'd40;

	// sensor formats
	localparam logic KIND_WORD = 1'b0;
	localparam logic KIND_BYTE = 1'b1;

	// read outcome codes
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_TIMEOUT  = 2'd1;
	localparam logic [1:0] STATUS_CHECKSUM = 2'd2;

	// input item actions
	localparam logic ACT_TICK  = 1'b0;
	localparam logic ACT_START = 1'b1;

	typedef struct packed {
		logic action;
		logic line_level;
	} req_t;

	typedef struct packed {
		logic               drive_enable;
		logic               drive_level;
		logic               busy_res;
		logic               done_res;
		logic [1:0]         status;
		logic [15:0]        humidity;
		logic signed [15:0] temperature;
	} rsp_t;

	typedef struct packed {
		logic                   sensor_kind;
		logic [TIMEOUT_W-1:0]   timeout_ticks;
		logic [THRESH_W-1:0]    bit_threshold;
		logic [PRE_HIGH_W-1:0]  pre_high_ticks;
		logic [START_LOW_W-1:0] start_low_ticks;
		logic [RELEASE_W-1:0]   release_high_ticks;
	} cfg_t;

	typedef struct packed {
		logic               sum_ok;
		logic [15:0]        humidity;
		logic signed [15:0] temperature;
	} dec_t;

endpackage

[rtl/core/pulse_width_sensor_frame_reader.sv]
// top level of the pulse width sensor frame reader: input stage, sequencer, result stage
// depends on pwsfr_pkg, pwsfr_cfg, pwsfr_seq (which uses pwsfr_decode)
//
// usage:
// - req channel: one beat per 1 us tick (action tick) or a start request, with the
//   sampled line level; a start while a read is running is ignored but still answered
// - rsp channel: exactly one beat per req beat, in order: line drive controls,
//   busy/done flags, last outcome and the last good humidity and temperature
// - wr port: register writes take effect at the clock edge with wr_en high;
//   write only while no read is running and the rsp channel is drained
// - path: an accepted req beat lands in the input stage; its rsp beat is registered in
//   the result stage once that stage is free, and is visible on rsp from then on
// - throughput: one beat per cycle while rsp is not stalled; the sequencer finishes
//   every beat combinationally between the input stage and the result stage
// - stall: when rsp_ready is low the result stage holds, the input stage holds one
//   more beat, then req_ready drops until the receiver takes the result
// - reset: arst_n clears both stages, returns the sequencer to idle with the line
//   released, clears status and stored values and loads the register defaults
module pulse_width_sensor_frame_reader
	import pwsfr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  req_t                  req_data,
	output logic                  rsp_valid,
	input  logic                  rsp_ready,
	output rsp_t                  rsp_data,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data
);

	logic valid_s1;
	req_t req_s1;
	logic valid_s2;
	rsp_t rsp_s2;
	logic advance;
	cfg_t cfg;
	rsp_t result;

	// beat moves from input stage to result stage when the result slot is free
	assign advance   = valid_s1 && (!valid_s2 || rsp_ready);
	assign req_ready = !valid_s1 || advance;

	pwsfr_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	pwsfr_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.step_en (advance),
		.item    (req_s1),
		.cfg     (cfg),
		.result  (result)
	);

	// stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (rsp_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req_data;
		end
		if (advance) begin
			rsp_s2 <= result;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp_data  = rsp_s2;

	// every beat leaving the input stage shows up on rsp
	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("input beat did not reach the result stage");

	// a blocked input stage keeps its beat
	a_s1_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(req_s1))
		else $error("input stage lost a beat while blocked");

	// a finishing beat has the line released and the sequencer idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && rsp_s2.done_res |-> !rsp_s2.busy_res && !rsp_s2.drive_enable)
		else $error("read finished while still busy or driving");

	// driving the line only happens during a read
	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && rsp_s2.drive_enable |-> rsp_s2.busy_res)
		else $error("line driven outside a read");

endmodule

[rtl/core/pwsfr_cfg.sv]
// configuration register file of the pulse width sensor frame reader
// depends on pwsfr_pkg for register indexes, widths and reset values
module pwsfr_cfg
	import pwsfr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  wr_en,
	input  logic [CFG_IDX_W-1:0]  wr_index,
	input  logic [CFG_DATA_W-1:0] wr_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	// register writes, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sensor_kind        <= RST_SENSOR_KIND;
			cfg_q.timeout_ticks      <= RST_TIMEOUT;
			cfg_q.bit_threshold      <= RST_BIT_THRESH;
			cfg_q.pre_high_ticks     <= RST_PRE_HIGH;
			cfg_q.start_low_ticks    <= RST_START_LOW;
			cfg_q.release_high_ticks <= RST_RELEASE_HIGH;
		end else if (wr_en) begin
			case (wr_index)
				REG_SENSOR_KIND:  cfg_q.sensor_kind        <= wr_data[0];
				REG_TIMEOUT:      cfg_q.timeout_ticks      <= wr_data[TIMEOUT_W-1:0];
				REG_BIT_THRESH:   cfg_q.bit_threshold      <= wr_data[THRESH_W-1:0];
				REG_PRE_HIGH:     cfg_q.pre_high_ticks     <= wr_data[PRE_HIGH_W-1:0];
				REG_START_LOW:    cfg_q.start_low_ticks    <= wr_data[START_LOW_W-1:0];
				REG_RELEASE_HIGH: cfg_q.release_high_ticks <= wr_data[RELEASE_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/core/pwsfr_decode.sv]
// frame checksum and humidity/temperature conversion, purely combinational
// depends on pwsfr_pkg for the frame size, sensor formats and dec_t
module pwsfr_decode
	import pwsfr_pkg::*;
(
	input  logic [FRAME_BITS-1:0] frame,
	input  logic                  sensor_kind,
	output dec_t                  dec
);

	logic [7:0]  b0, b1, b2, b3, b4;
	logic [7:0]  sum;
	logic [14:0] mag;
	logic [15:0] temp_word;

	// split frame into bytes, msb first
	assign b0 = frame[39:32];
	assign b1 = frame[31:24];
	assign b2 = frame[23:16];
	assign b3 = frame[15:8];
	assign b4 = frame[7:0];

	// low byte of the byte sum must match the last byte
	assign sum = 8'(b0 + b1 + b2 + b3);

	// sign-magnitude temperature for the word format
	assign mag = {b2[6:0], b3};
	assign temp_word = b2[7] ? 16'(16'd0 - {1'b0, mag}) : {1'b0, mag};

	// checksum flag and format select
	always_comb begin
		dec.sum_ok = (sum == b4);
		if (sensor_kind == KIND_BYTE) begin
			dec.humidity    = {8'd0, b0};
			dec.temperature = $signed({8'd0, b2});
		end else begin
			dec.humidity    = {b0, b1};
			dec.temperature = $signed(temp_word);
		end
	end

endmodule

[rtl/core/pwsfr_seq.sv]
// read sequencer: start pulse timing, edge capture, bit decode and result update
// depends on pwsfr_pkg and pwsfr_decode
module pwsfr_seq
	import pwsfr_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic step_en,
	input  req_t item,
	input  cfg_t cfg,
	output rsp_t result
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_PRE,
		PH_LOW,
		PH_REL,
		PH_CAP
	} phase_t;

	phase_t                   phase_q, phase_d;
	logic [PHASE_TICKS_W-1:0] ticks_q, ticks_d, ticks_inc, phase_len;
	logic [EDGE_CNT_W-1:0]    edge_q, edge_d;
	logic                     last_q, last_d;
	logic [PULSE_W-1:0]       pulse_q, pulse_d;
	logic [BIT_CNT_W-1:0]     bits_q, bits_d;
	logic [FRAME_BITS-1:0]    frame_q, frame_d, frame_shift;
	logic [15:0]              hum_q, hum_d;
	logic signed [15:0]       temp_q, temp_d;
	logic [1:0]               stat_q, stat_d;
	logic                     done;
	logic                     edge_seen, take_bit;
	logic [PULSE_W:0]         cnt;
	phase_t                   start_phase, after_phase;
	dec_t                     dec;

	// edge detect and bit slicing on the current sample
	assign edge_seen   = (item.line_level != last_q);
	assign take_bit    = edge_seen && (edge_q >= EDGE_CNT_W'(4)) && !edge_q[0];
	assign frame_shift = {frame_q[FRAME_BITS-2:0], (pulse_q > cfg.bit_threshold)};
	assign cnt         = edge_seen ? (PULSE_W+1)'(1) : ({1'b0, pulse_q} + (PULSE_W+1)'(1));

	pwsfr_decode u_decode (
		.frame       (frame_shift),
		.sensor_kind (cfg.sensor_kind),
		.dec         (dec)
	);

	// driven phase selection, zero-length phases skipped
	always_comb begin
		if (cfg.release_high_ticks == '0) begin
			after_phase = PH_CAP;
		end else begin
			after_phase = PH_REL;
		end
		case (phase_q)
			PH_PRE: begin
				phase_len = cfg.pre_high_ticks;
				if (cfg.start_low_ticks != '0) begin
					after_phase = PH_LOW;
				end
			end
			PH_LOW: phase_len = {2'd0, cfg.start_low_ticks};
			PH_REL: begin
				phase_len   = {10'd0, cfg.release_high_ticks};
				after_phase = PH_CAP;
			end
			default: phase_len = '0;
		endcase
		if (cfg.pre_high_ticks != '0) begin
			start_phase = PH_PRE;
		end else if (cfg.start_low_ticks != '0) begin
			start_phase = PH_LOW;
		end else if (cfg.release_high_ticks != '0) begin
			start_phase = PH_REL;
		end else begin
			start_phase = PH_CAP;
		end
	end

	assign ticks_inc = ticks_q + PHASE_TICKS_W'(1);

	// next state for one beat
	always_comb begin
		phase_d = phase_q;
		ticks_d = ticks_q;
		edge_d  = edge_q;
		last_d  = last_q;
		pulse_d = pulse_q;
		bits_d  = bits_q;
		frame_d = frame_q;
		hum_d   = hum_q;
		temp_d  = temp_q;
		stat_d  = stat_q;
		done    = 1'b0;
		if (step_en) begin
			if (item.action == ACT_START) begin
				if (phase_q == PH_IDLE) begin
					frame_d = '0;
					bits_d  = '0;
					edge_d  = '0;
					last_d  = 1'b1;
					pulse_d = '0;
					ticks_d = '0;
					phase_d = start_phase;
				end
			end else begin
				case (phase_q)
					PH_PRE, PH_LOW, PH_REL: begin
						if (ticks_inc >= phase_len) begin
							ticks_d = '0;
							phase_d = after_phase;
						end else begin
							ticks_d = ticks_inc;
						end
					end
					PH_CAP: begin
						if (edge_seen) begin
							last_d = item.line_level;
							if (edge_q != '1) begin
								edge_d = edge_q + EDGE_CNT_W'(1);
							end
						end
						if (take_bit) begin
							frame_d = frame_shift;
							bits_d  = bits_q + BIT_CNT_W'(1);
						end
						if (bits_d >= BIT_CNT_W'(FRAME_BITS)) begin
							if (dec.sum_ok) begin
								stat_d = STATUS_OK;
								hum_d  = dec.humidity;
								temp_d = dec.temperature;
							end else begin
								stat_d = STATUS_CHECKSUM;
							end
							phase_d = PH_IDLE;
							done    = 1'b1;
						end else if (cnt > {1'b0, cfg.timeout_ticks} || cnt[PULSE_W]) begin
							stat_d  = STATUS_TIMEOUT;
							phase_d = PH_IDLE;
							done    = 1'b1;
						end else begin
							pulse_d = cnt[PULSE_W-1:0];
						end
					end
					default: phase_d = PH_IDLE;
				endcase
			end
		end
	end

	// result for this beat, taken from the updated state
	always_comb begin
		result.drive_enable = (phase_d inside {PH_PRE, PH_LOW, PH_REL});
		result.drive_level  = (phase_d inside {PH_PRE, PH_REL});
		result.busy_res     = (phase_d != PH_IDLE);
		result.done_res     = done;
		result.status       = stat_d;
		result.humidity     = hum_d;
		result.temperature  = temp_d;
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			ticks_q <= '0;
			edge_q  <= '0;
			last_q  <= 1'b1;
			pulse_q <= '0;
			bits_q  <= '0;
			frame_q <= '0;
			hum_q   <= '0;
			temp_q  <= '0;
			stat_q  <= STATUS_OK;
		end else begin
			phase_q <= phase_d;
			ticks_q <= ticks_d;
			edge_q  <= edge_d;
			last_q  <= last_d;
			pulse_q <= pulse_d;
			bits_q  <= bits_d;
			frame_q <= frame_d;
			hum_q   <= hum_d;
			temp_q  <= temp_d;
			stat_q  <= stat_d;
		end
	end

endmodule

[tb/pulse_width_sensor_frame_reader_tb.sv]
// testbench for pulse_width_sensor_frame_reader: drives tick and start beats, shadows the
// reader state in a small scoreboard class and checks every response beat field by field
// depends on pwsfr_pkg and the reader rtl
module pulse_width_sensor_frame_reader_tb;
	import pwsfr_pkg::*;

	localparam int CYCLE_LIMIT = 100000;
	localparam int MAX_REPORTS = 100;
	localparam logic [5:0] ALL_REGS = 6'b111111;
	localparam logic [5:0] DRIVE_REGS = (6'd1 << REG_PRE_HIGH) | (6'd1 << REG_START_LOW) |
		(6'd1 << REG_RELEASE_HIGH);
	localparam logic [5:0] THRESH_REGS = 6'd1 << REG_BIT_THRESH;

	typedef enum logic [2:0] {PH_IDLE, PH_PRE, PH_LOW, PH_REL, PH_CAP} seq_phase_e;

	// shadow of the reader: predicts each response beat and checks the ones that come out
	class reader_shadow;
		cfg_t               cfg;
		seq_phase_e         phase;
		logic [17:0]        phase_ticks;
		logic [6:0]         edge_count;
		logic               last_level;
		logic [7:0]         pulse_ticks;
		logic [5:0]         bit_count;
		logic [39:0]        frame;
		logic [15:0]        hum;
		logic [15:0]        temp;
		logic [1:0]         status;
		rsp_t               due_outputs[$];
		int                 errors;
		int                 beats;

		function new();
			cfg.sensor_kind = RST_SENSOR_KIND;
			cfg.timeout_ticks = RST_TIMEOUT;
			cfg.bit_threshold = RST_BIT_THRESH;
			cfg.pre_high_ticks = RST_PRE_HIGH;
			cfg.start_low_ticks = RST_START_LOW;
			cfg.release_high_ticks = RST_RELEASE_HIGH;
			phase = PH_IDLE;
			phase_ticks = '0;
			edge_count = '0;
			last_level = 1'b1;
			pulse_ticks = '0;
			bit_count = '0;
			frame = '0;
			hum = '0;
			temp = '0;
			status = STATUS_OK;
			errors = 0;
			beats = 0;
		endfunction

		function bit busy();
			return phase != PH_IDLE;
		endfunction

		// driven phases of length zero are skipped
		function void enter_phase(seq_phase_e p);
			phase_ticks = '0;
			if (p == PH_PRE && cfg.pre_high_ticks == 0) p = PH_LOW;
			if (p == PH_LOW && cfg.start_low_ticks == 0) p = PH_REL;
			if (p == PH_REL && cfg.release_high_ticks == 0) p = PH_CAP;
			phase = p;
		endfunction

		// checksum, then humidity and temperature in the selected format
		function void decode_frame();
			logic [7:0]  b0, b1, b2, b3, b4, sum;
			logic [15:0] mag;
			b0 = frame[39:32];
			b1 = frame[31:24];
			b2 = frame[23:16];
			b3 = frame[15:8];
			b4 = frame[7:0];
			sum = b0 + b1 + b2 + b3;
			if (sum != b4) begin
				status = STATUS_CHECKSUM;
			end else begin
				status = STATUS_OK;
				if (cfg.sensor_kind == KIND_BYTE) begin
					hum = {8'h00, b0};
					temp = {8'h00, b2};
				end else begin
					mag = {1'b0, b2[6:0], b3};
					hum = {b0, b1};
					temp = b2[7] ? 16'h0000 - mag : mag;
				end
			end
		endfunction

		// advance the shadow by one accepted request beat and queue its response
		function void note_beat(req_t item);
			rsp_t       want;
			logic [8:0] cnt;
			logic       done;
			int         len;
			done = 1'b0;
			if (item.action == ACT_START) begin
				// a start while busy is ignored
				if (phase == PH_IDLE) begin
					frame = '0;
					bit_count = '0;
					edge_count = '0;
					last_level = 1'b1;
					pulse_ticks = '0;
					enter_phase(PH_PRE);
				end
			end else if (phase == PH_PRE || phase == PH_LOW || phase == PH_REL) begin
				// driven phases: line level is ignored
				len = (phase == PH_PRE) ? int'(cfg.pre_high_ticks) :
					(phase == PH_LOW) ? int'(cfg.start_low_ticks) : int'(cfg.release_high_ticks);
				phase_ticks = phase_ticks + 18'd1;
				if (int'(phase_ticks) >= len) enter_phase(seq_phase_e'(phase + 3'd1));
			end else if (phase == PH_CAP) begin
				// capture: every even edge from the fourth ends a high pulse
				if (item.line_level != last_level) begin
					if (edge_count >= 4 && !edge_count[0]) begin
						frame = {frame[38:0], pulse_ticks > cfg.bit_threshold};
						bit_count = bit_count + 6'd1;
					end
					last_level = item.line_level;
					if (edge_count < 7'd127) edge_count = edge_count + 7'd1;
					cnt = 9'd1;
				end else begin
					cnt = pulse_ticks + 9'd1;
				end
				if (bit_count >= FRAME_BITS) begin
					decode_frame();
					phase = PH_IDLE;
					done = 1'b1;
				end else if (cnt > cfg.timeout_ticks || cnt > 9'd255) begin
					status = STATUS_TIMEOUT;
					phase = PH_IDLE;
					done = 1'b1;
				end else begin
					pulse_ticks = cnt[7:0];
				end
			end
			want.drive_enable = (phase == PH_PRE || phase == PH_LOW || phase == PH_REL);
			want.drive_level = (phase == PH_PRE || phase == PH_REL);
			want.busy_res = (phase != PH_IDLE);
			want.done_res = done;
			want.status = status;
			want.humidity = hum;
			want.temperature = temp;
			due_outputs.push_back(want);
		endfunction

		// one line per mismatch, log kept short on a badly broken run
		task report(string what, logic [39:0] got_val, logic [39:0] want_val);
			errors++;
			if (errors <= MAX_REPORTS)
				$display("mismatch at response %0d, %s: got %0h, expected %0h",
					beats, what, got_val, want_val);
		endtask

		// compare one response beat with the oldest prediction
		task check_beat(rsp_t got);
			rsp_t want;
			beats++;
			if (due_outputs.size() == 0) begin
				report("response beat with none expected", 40'(got), '0);
			end else begin
				want = due_outputs.pop_front();
				if (got.drive_enable !== want.drive_enable)
					report("drive_enable", 40'(got.drive_enable), 40'(want.drive_enable));
				if (got.drive_level !== want.drive_level)
					report("drive_level", 40'(got.drive_level), 40'(want.drive_level));
				if (got.busy_res !== want.busy_res)
					report("busy_res", 40'(got.busy_res), 40'(want.busy_res));
				if (got.done_res !== want.done_res)
					report("done_res", 40'(got.done_res), 40'(want.done_res));
				if (got.status !== want.status)
					report("status", 40'(got.status), 40'(want.status));
				if (got.humidity !== want.humidity)
					report("humidity", 40'(got.humidity), 40'(want.humidity));
				if (got.temperature !== want.temperature)
					report("temperature", 40'(got.temperature), 40'(want.temperature));
			end
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  req_valid;
	logic                  req_ready;
	req_t                  req_data;
	logic                  rsp_valid;
	logic                  rsp_ready;
	rsp_t                  rsp_data;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;

	reader_shadow shadow;
	bit           calm;
	int           items_sent;
	int           cycles;

	pulse_width_sensor_frame_reader i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver stalls at random outside the calm stretch
	always @(negedge clk) begin
		rsp_ready <= calm || ($urandom_range(99) >= 17);
	end

	// check every accepted response beat
	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) shadow.check_beat(rsp_data);
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// send one request beat; called and returns at a falling edge
	task automatic send_item(logic action, logic level);
		req_t item;
		item.action = action;
		item.line_level = level;
		if (!calm && $urandom_range(99) < 10) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		req_valid <= 1'b1;
		req_data <= item;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		shadow.note_beat(item);
		items_sent++;
		@(negedge clk);
	endtask

	// hold the line at one level for up to n ticks, stopping once the read ends
	task automatic hold_level(logic level, int n);
		for (int k = 0; k < n && shadow.busy(); k++) send_item(ACT_TICK, level);
	endtask

	// keep the line steady until the running read ends
	task automatic finish_read();
		while (shadow.busy()) send_item(ACT_TICK, shadow.last_level);
	endtask

	// pause the sender until every predicted response beat has come out
	task automatic drain();
		if (req_valid) req_valid <= 1'b0;
		while (shadow.due_outputs.size() != 0) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] value);
		wr_en <= 1'b1;
		wr_index <= index;
		wr_data <= value;
		@(negedge clk);
	endtask

	// write the selected registers with the reader idle and drained
	task automatic load_config(cfg_t c, logic [5:0] mask);
		finish_read();
		drain();
		if (mask[REG_SENSOR_KIND]) begin
			write_reg(REG_SENSOR_KIND, CFG_DATA_W'(c.sensor_kind));
			shadow.cfg.sensor_kind = c.sensor_kind;
		end
		if (mask[REG_TIMEOUT]) begin
			write_reg(REG_TIMEOUT, CFG_DATA_W'(c.timeout_ticks));
			shadow.cfg.timeout_ticks = c.timeout_ticks;
		end
		if (mask[REG_BIT_THRESH]) begin
			write_reg(REG_BIT_THRESH, CFG_DATA_W'(c.bit_threshold));
			shadow.cfg.bit_threshold = c.bit_threshold;
		end
		if (mask[REG_PRE_HIGH]) begin
			write_reg(REG_PRE_HIGH, c.pre_high_ticks);
			shadow.cfg.pre_high_ticks = c.pre_high_ticks;
		end
		if (mask[REG_START_LOW]) begin
			write_reg(REG_START_LOW, CFG_DATA_W'(c.start_low_ticks));
			shadow.cfg.start_low_ticks = c.start_low_ticks;
		end
		if (mask[REG_RELEASE_HIGH]) begin
			write_reg(REG_RELEASE_HIGH, CFG_DATA_W'(c.release_high_ticks));
			shadow.cfg.release_high_ticks = c.release_high_ticks;
		end
		wr_en <= 1'b0;
	endtask

	// random 40-bit frame, last byte the byte sum unless corrupted
	function automatic logic [39:0] make_frame(bit corrupt);
		logic [7:0] b0, b1, b2, b3, sum;
		b0 = 8'($urandom);
		b1 = 8'($urandom);
		b2 = 8'($urandom);
		b3 = 8'($urandom);
		sum = b0 + b1 + b2 + b3;
		if (corrupt) sum = sum ^ 8'($urandom_range(1, 255));
		return {b0, b1, b2, b3, sum};
	endfunction

	// full read: start, driven phases, sensor answer, then the data pulses;
	// cut_at stops early, glitch_at adds a stray edge pair
	task automatic send_frame(logic [39:0] bits, int cut_at, int glitch_at);
		int thr;
		int h;
		finish_read();
		send_item(ACT_START, 1'($urandom_range(1)));
		while (shadow.busy() && shadow.phase != PH_CAP)
			send_item(ACT_TICK, 1'($urandom_range(1)));
		thr = shadow.cfg.bit_threshold;
		// sensor answer: optional wait, low, high, low
		hold_level(1'b1, $urandom_range(0, 2));
		hold_level(1'b0, $urandom_range(1, 3));
		hold_level(1'b1, $urandom_range(1, 3));
		hold_level(1'b0, $urandom_range(1, 3));
		for (int i = 39; i >= 0 && i != cut_at && shadow.busy(); i--) begin
			// pulse lengths sit right at the threshold on either side
			if (bits[i]) h = thr + 1 + $urandom_range(0, 2);
			else h = (thr == 0) ? 1 : thr - $urandom_range(0, (thr > 2) ? 2 : thr - 1);
			if (h > 255) h = 255;
			hold_level(1'b1, h);
			if (i == glitch_at) begin
				hold_level(1'b0, 1);
				hold_level(1'b1, 1);
			end
			if ($urandom_range(99) < 2 && shadow.busy())
				send_item(ACT_START, 1'($urandom_range(1)));
			if ($urandom_range(199) == 0) drain();
			hold_level(1'b0, $urandom_range(1, 3));
		end
	endtask

	// small random settings so frames stay short
	task automatic random_config();
		cfg_t c;
		c.sensor_kind = 1'($urandom_range(1));
		c.bit_threshold = 8'($urandom_range(0, 3));
		c.timeout_ticks = ($urandom_range(99) < 15) ? 8'($urandom_range(1, 5)) :
			8'($urandom_range(8, 40));
		c.pre_high_ticks = 18'($urandom_range(0, 4));
		c.start_low_ticks = 16'($urandom_range(0, 3));
		c.release_high_ticks = 8'($urandom_range(0, 3));
		load_config(c, ALL_REGS);
	endtask

	// mostly well-formed reads, some broken ones, some noise
	task automatic random_episode();
		int pick;
		pick = $urandom_range(99);
		if (pick < 70) begin
			send_frame(make_frame($urandom_range(99) < 15),
				($urandom_range(99) < 8) ? $urandom_range(0, 39) : -1,
				($urandom_range(99) < 8) ? $urandom_range(0, 39) : -1);
		end else if (pick < 85) begin
			repeat ($urandom_range(5, 30))
				send_item(1'($urandom_range(1)), 1'($urandom_range(1)));
		end else begin
			finish_read();
			send_item(ACT_START, 1'($urandom_range(1)));
			finish_read();
		end
	endtask

	initial begin
		cfg_t c;
		int   target;
		shadow = new();
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		rsp_ready = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		calm = 1'b0;
		items_sent = 0;
		cycles = 0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// short driven phases, reset values elsewhere
		c = shadow.cfg;
		c.pre_high_ticks = 18'd3;
		c.start_low_ticks = 16'd2;
		c.release_high_ticks = 8'd1;
		load_config(c, DRIVE_REGS);

		// ticks while idle, start, start while busy, line ignored while driving
		send_item(ACT_TICK, 1'b0);
		send_item(ACT_TICK, 1'b1);
		send_item(ACT_START, 1'b0);
		send_item(ACT_START, 1'b1);
		while (shadow.phase != PH_CAP) send_item(ACT_TICK, 1'($urandom_range(1)));
		send_item(ACT_TICK, 1'b1);
		send_item(ACT_TICK, 1'b0);
		send_item(ACT_START, 1'b1);
		drain();
		send_item(ACT_TICK, 1'b0);
		finish_read();

		// full read with default format and timeout, short threshold
		c.bit_threshold = 8'd1;
		load_config(c, THRESH_REGS);
		send_frame(make_frame(1'b0), -1, -1);

		// all driven phases skipped, timeout zero fails on the first counted tick
		c.sensor_kind = KIND_BYTE;
		c.timeout_ticks = 8'd0;
		c.bit_threshold = 8'd0;
		c.pre_high_ticks = 18'd0;
		c.start_low_ticks = 16'd0;
		c.release_high_ticks = 8'd0;
		load_config(c, ALL_REGS);
		send_item(ACT_START, 1'b1);
		send_item(ACT_TICK, 1'b1);
		send_item(ACT_START, 1'b0);
		send_item(ACT_TICK, 1'b0);

		// random part, one phase without any idling
		for (int p = 0; p < 3; p++) begin
			calm = (p == 1);
			random_config();
			target = items_sent + 60;
			while (items_sent < target) random_episode();
		end
		calm = 1'b0;

		// top timeout, then a 256-tick level
		c.sensor_kind = KIND_WORD;
		c.timeout_ticks = 8'd255;
		c.bit_threshold = 8'd254;
		c.pre_high_ticks = 18'd1;
		c.start_low_ticks = 16'd1;
		c.release_high_ticks = 8'd1;
		load_config(c, ALL_REGS);
		send_frame(make_frame(1'b0), 39, -1);
		finish_read();

		drain();
		repeat (4) @(negedge clk);
		if (shadow.errors == 0 && shadow.due_outputs.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end
endmodule

[pulse_width_sensor_frame_reader.f]
rtl/core/pwsfr_pkg.sv
rtl/core/pwsfr_cfg.sv
rtl/core/pwsfr_decode.sv
rtl/core/pwsfr_seq.sv
rtl/core/pulse_width_sensor_frame_reader.sv
tb/pulse_width_sensor_frame_reader_tb.sv
